// ===== hdl/aesbm_pkg.sv =====
`timescale 1ns / 1ps
package aesbm_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [2:0] {
    MODE_ECB_ENC = 3'd0,
    MODE_ECB_DEC = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_KEY_HI = 3'd1,
    REG_KEY_LO = 3'd2,
    REG_IV_HI  = 3'd3,
    REG_IV_LO  = 3'd4
  } reg_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, set up first state
    logic key_step;   // advance key schedule one round
    logic round;      // run one cipher round
    logic last;       // final round (no mix)
    logic finish;     // build result, update chain/counter
    logic key_start;  // restart key schedule from the key
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic decrypt;    // current item needs the inverse cipher
    logic bypass;     // unused mode, no cipher work
  } stat_t;

  function automatic logic [7:0] xt(input logic [7:0] b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    inv_sbox = t[x];
  endfunction

  // byte i of a 128-bit block, byte 0 most significant
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    get_byte = s[127-8*i -: 8];
  endfunction

  // one forward key schedule step; rc is the round constant
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_fwd = {w0, w1, w2, w3};
  endfunction

  // one reverse key schedule step (undoes key_fwd with the same rc)
  function automatic logic [127:0] key_rev(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    {w0, w1, w2, w3} = k;
    w3 = w3 ^ w2;
    w2 = w2 ^ w1;
    w1 = w1 ^ w0;
    t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t;
    key_rev = {w0, w1, w2, w3};
  endfunction

  function automatic logic [7:0] rc_next(input logic [7:0] rc);
    rc_next = xt(rc);
  endfunction

  // inverse of xt over the round constants in use
  function automatic logic [7:0] rc_prev(input logic [7:0] rc);
    rc_prev = rc[0] ? ({1'b1, rc[7:1]} ^ 8'h0d) : {1'b0, rc[7:1]};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[rr+4*c] = sbox(get_byte(s, rr + 4*((c + rr) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        r[127-32*c -: 32] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      end else begin
        r[127-32*c -: 32] = {
          gmul(t[4*c],4'd2) ^ gmul(t[4*c+1],4'd3) ^ t[4*c+2] ^ t[4*c+3],
          t[4*c] ^ gmul(t[4*c+1],4'd2) ^ gmul(t[4*c+2],4'd3) ^ t[4*c+3],
          t[4*c] ^ t[4*c+1] ^ gmul(t[4*c+2],4'd2) ^ gmul(t[4*c+3],4'd3),
          gmul(t[4*c],4'd3) ^ t[4*c+1] ^ t[4*c+2] ^ gmul(t[4*c+3],4'd2)};
      end
    end
    enc_round = r;
  endfunction

  // inverse shift and substitution; the optional inverse mix after key add is inv_mix
  function automatic logic [127:0] dec_sub(input logic [127:0] s);
    logic [7:0] t [16];
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[rr + 4*((c + rr) % 4)] = inv_sbox(get_byte(s, rr + 4*c));
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
    dec_sub = r;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      r[127-32*c -: 32] = {
        gmul(a0,4'd14) ^ gmul(a1,4'd11) ^ gmul(a2,4'd13) ^ gmul(a3,4'd9),
        gmul(a0,4'd9) ^ gmul(a1,4'd14) ^ gmul(a2,4'd11) ^ gmul(a3,4'd13),
        gmul(a0,4'd13) ^ gmul(a1,4'd9) ^ gmul(a2,4'd14) ^ gmul(a3,4'd11),
        gmul(a0,4'd11) ^ gmul(a1,4'd13) ^ gmul(a2,4'd9) ^ gmul(a3,4'd14)};
    end
    inv_mix = r;
  endfunction

endpackage

// ===== hdl/aesbm_ctrl.sv =====
`timescale 1ns / 1ps
module aesbm_ctrl
  import aesbm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  logic  key_write_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_KEY   = 5'b00010,
    ST_RUN   = 5'b00100,
    ST_DONE  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  // decrypt key (last round key) is valid for the current key
  logic dkey_ok_q, dkey_ok_d;
  logic need_key;

  // hold off decrypt items until the last round key is ready
  assign need_key    = stat_i.decrypt && !dkey_ok_q;
  assign in_ready_o  = !need_key &&
                       ((state_q == ST_IDLE) || (state_q == ST_OUT && out_ready_i));
  assign out_valid_o = (state_q == ST_OUT);

  // sequence one item through load, ten rounds (none in an unused mode) and finish
  always_comb begin
    logic take;
    take = in_valid_i && in_ready_o;
    state_d = state_q;
    cnt_d = cnt_q;
    dkey_ok_d = dkey_ok_q && !key_write_i;
    ctrl_o = '0;
    case (state_q)
      ST_IDLE, ST_OUT: begin
        if (state_q == ST_OUT && out_ready_i) state_d = ST_IDLE;
        if (take) begin
          ctrl_o.load = 1'b1;
          state_d = ST_RUN;
          cnt_d = '0;
        end else if (state_q == ST_IDLE && need_key && !key_write_i) begin
          // start the key walk from the stored key
          ctrl_o.key_start = 1'b1;
          state_d = ST_KEY;
          cnt_d = '0;
        end
      end
      ST_KEY: begin
        if (key_write_i) begin
          // drop the walk, the key is changing
          state_d = ST_IDLE;
          cnt_d = '0;
        end else begin
          // walk key forward to the last round key for decryption
          ctrl_o.key_step = 1'b1;
          cnt_d = cnt_q + 4'd1;
          if (cnt_q == 4'(NumRounds - 1)) begin
            dkey_ok_d = 1'b1;
            state_d = ST_IDLE;
            cnt_d = '0;
          end
        end
      end
      ST_RUN: begin
        if (stat_i.bypass) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.round = 1'b1;
          ctrl_o.last = (cnt_q == 4'(NumRounds - 1));
          cnt_d = cnt_q + 4'd1;
          if (ctrl_o.last) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        ctrl_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      dkey_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      dkey_ok_q <= dkey_ok_d;
    end
  end

endmodule

// ===== hdl/aesbm_dp.sv =====
`timescale 1ns / 1ps
module aesbm_dp
  import aesbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic [63:0] data_hi_i,
  input  logic [63:0] data_lo_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        first_block_i,
  output logic [63:0] out_hi_o,
  output logic [63:0] out_lo_o
);

  logic [2:0]   mode_q;
  logic [127:0] key_q, iv_q;
  logic [127:0] chain_q, chain_d;
  logic [63:0]  ctr_q, ctr_d;
  // last round key, derived after a key write once a decrypt mode is set
  logic [127:0] dkey_q;
  logic [127:0] rk_q, rk_d;
  logic [7:0]   rc_q, rc_d;
  logic [127:0] st_q, st_d;
  logic [127:0] din_q;
  logic [4:0]   vb_q;
  logic [127:0] res_q;
  logic         wr;

  assign wr = cfg_valid_i && cfg_ready_i;
  assign stat_o.decrypt = (mode_q == MODE_ECB_DEC) || (mode_q == MODE_CBC_DEC);
  assign stat_o.bypass = mode_q > MODE_CTR;
  assign out_hi_o = res_q[127:64];
  assign out_lo_o = res_q[63:0];

  // configuration registers and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
      key_q <= '0;
      iv_q <= '0;
      chain_q <= '0;
      ctr_q <= '0;
    end else begin
      if (wr) begin
        case (cfg_index_i)
          REG_MODE:   mode_q <= cfg_data_i[2:0];
          REG_KEY_HI: key_q[127:64] <= cfg_data_i;
          REG_KEY_LO: key_q[63:0] <= cfg_data_i;
          REG_IV_HI:  iv_q[127:64] <= cfg_data_i;
          REG_IV_LO:  iv_q[63:0] <= cfg_data_i;
          default: ;
        endcase
      end
      chain_q <= chain_d;
      ctr_q <= ctr_d;
    end
  end

  // round engine: one round and one key step per cycle; also item load, key walk and finish
  always_comb begin
    logic [127:0] chain_v, blk, x;
    logic [63:0]  ctr_v;
    logic [127:0] ks;
    chain_d = chain_q;
    ctr_d = ctr_q;
    rk_d = rk_q;
    rc_d = rc_q;
    st_d = st_q;
    chain_v = first_block_i ? iv_q : chain_q;
    ctr_v = first_block_i ? '0 : ctr_q;
    blk = {data_hi_i, data_lo_i};
    x = '0;
    ks = '0;
    if (ctrl_i.key_step) begin
      rk_d = key_fwd(rk_q, rc_q);
      rc_d = rc_next(rc_q);
    end
    if (ctrl_i.load) begin
      chain_d = chain_v;
      ctr_d = ctr_v;
      case (mode_q)
        MODE_ECB_ENC: x = blk ^ key_q;
        MODE_CBC_ENC: x = blk ^ chain_v ^ key_q;
        MODE_CTR: begin
          for (int i = 0; i < 8; i++) ks[63-8*i -: 8] = ctr_v[8*i +: 8];
          x = {iv_q[127:64], ks[63:0]} ^ key_q;
        end
        default: x = blk ^ dkey_q;
      endcase
      st_d = x;
      if (stat_o.decrypt) begin
        rk_d = key_rev(dkey_q, 8'h36);
        rc_d = rc_prev(8'h36);
      end else begin
        rk_d = key_fwd(key_q, 8'h01);
        rc_d = 8'h02;
      end
    end
    if (ctrl_i.round) begin
      if (stat_o.decrypt) begin
        x = dec_sub(st_q) ^ rk_q;
        st_d = ctrl_i.last ? x : inv_mix(x);
        rk_d = key_rev(rk_q, rc_q);
        rc_d = rc_prev(rc_q);
      end else begin
        st_d = enc_round(st_q, ctrl_i.last) ^ rk_q;
        rk_d = key_fwd(rk_q, rc_q);
        rc_d = rc_next(rc_q);
      end
    end
    if (ctrl_i.key_start) begin
      rk_d = key_q;
      rc_d = 8'h01;
    end
    if (ctrl_i.finish) begin
      case (mode_q)
        MODE_CBC_ENC: chain_d = st_q;
        MODE_CBC_DEC: chain_d = din_q;
        MODE_CTR:     ctr_d = ctr_q + 64'd1;
        default: ;
      endcase
    end
  end

  // item payload, round state and result
  always_ff @(posedge clk_i) begin
    logic [127:0] r;
    rk_q <= rk_d;
    rc_q <= rc_d;
    st_q <= st_d;
    if (ctrl_i.key_step && rc_q == 8'h36) dkey_q <= rk_d;
    if (ctrl_i.load) begin
      din_q <= {data_hi_i, data_lo_i};
      vb_q <= valid_bytes_i;
    end
    if (ctrl_i.finish) begin
      case (mode_q)
        MODE_ECB_ENC, MODE_ECB_DEC, MODE_CBC_ENC: r = st_q;
        MODE_CBC_DEC: r = st_q ^ chain_q;
        MODE_CTR: begin
          r = st_q ^ din_q;
          for (int i = 0; i < 16; i++) begin
            if (5'(i) >= vb_q) r[127-8*i -: 8] = 8'h00;
          end
        end
        default: r = '0;
      endcase
      res_q <= r;
    end
  end

endmodule

// ===== hdl/aes128_block_mode_engine.sv =====
`timescale 1ns / 1ps
// AES-128 engine for ECB, CBC and CTR, one 128-bit block per item. An item
// goes through load, ten rounds on one shared round unit (none in an unused
// mode) and finish; the next item is taken as the result is delivered. After
// a key write, while a decrypt mode is set, the input is held off while the
// key schedule is walked forward to the last round key. Configuration writes
// are taken at any time but must only be made while the block is idle.
module aes128_block_mode_engine
  import aesbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_hi_i,
  input  logic [63:0] data_lo_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        first_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_hi_o,
  output logic [63:0] out_lo_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  key_write;

  assign cfg_ready_o = 1'b1;
  assign key_write = cfg_valid_i &&
    (cfg_index_i == REG_KEY_HI || cfg_index_i == REG_KEY_LO);

  aesbm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .key_write_i(key_write), .stat_i(stat), .ctrl_o(ctrl)
  );

  aesbm_dp u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .data_hi_i, .data_lo_i, .valid_bytes_i, .first_block_i,
    .out_hi_o, .out_lo_o
  );

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.round |-> !in_ready_o) else $error("item taken while busy");
  a_finish_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |=> out_valid_o) else $error("finish without result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_hi_o))
    else $error("result dropped");
`endif

endmodule

// ===== tb/aes128_block_mode_engine_test.sv =====
`timescale 1ns / 1ps
module aes128_block_mode_engine_test;
  import aesbm_pkg::*;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        first;
  } block_item_t;

  localparam logic [2:0] ModeSpare5  = 3'd5;
  localparam logic [2:0] ModeSpare7  = 3'd7;
  localparam logic [2:0] RegUnused   = 3'd6;
  localparam int         IdleLimit   = 20000;
  localparam int         SettleCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic [63:0] data_hi = '0;
  logic [63:0] data_lo = '0;
  logic [4:0]  valid_bytes = '0;
  logic        first_block = 1'b0;
  logic        out_ready = 1'b0;
  logic        cfg_ready_o, in_ready_o, out_valid_o;
  logic [63:0] out_hi_o, out_lo_o;

  // shadow of the block's registers and message state
  logic [2:0]   cur_mode;
  logic [63:0]  cur_key_hi, cur_key_lo, cur_iv_hi, cur_iv_lo;
  logic [127:0] chain_val = '0;
  logic [63:0]  blk_count = '0;
  logic [127:0] rkey [11];
  logic [7:0]   sb_fwd [256];
  logic [7:0]   sb_inv [256];

  block_item_t  pending_blocks [$];
  logic [127:0] expected_blocks [$];
  int           in_gap, out_gap;
  bit           in_burst, out_burst;
  int           idle_cycles;
  bit           failed;

  aes128_block_mode_engine dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o, .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o,
    .data_hi_i(data_hi), .data_lo_i(data_lo),
    .valid_bytes_i(valid_bytes), .first_block_i(first_block),
    .out_valid_o, .out_ready_i(out_ready), .out_hi_o, .out_lo_o
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rot8(input logic [7:0] b, input int k);
    return (b << k) | (b >> (8 - k));
  endfunction

  // derive both substitution tables from the field inverse and the affine map
  function automatic void fill_sboxes();
    logic [7:0] p, q;
    for (int x = 0; x < 256; x++) begin
      p = 8'h01;
      for (int i = 0; i < 254; i++) p = gf_mul(p, x[7:0]);
      if (x == 0) p = 8'h00;
      q = p ^ rot8(p, 1) ^ rot8(p, 2) ^ rot8(p, 3) ^ rot8(p, 4) ^ 8'h63;
      sb_fwd[x] = q;
      sb_inv[q] = x[7:0];
    end
  endfunction

  function automatic void expand_key();
    logic [31:0] w0, w1, w2, w3, t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    rkey[0] = {cur_key_hi, cur_key_lo};
    for (int r = 1; r <= 10; r++) begin
      {w0, w1, w2, w3} = rkey[r-1];
      t = {sb_fwd[w3[23:16]] ^ rcon, sb_fwd[w3[15:8]], sb_fwd[w3[7:0]], sb_fwd[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      rkey[r] = {w0, w1, w2, w3};
      rcon = xtime(rcon);
    end
  endfunction

  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // state bytes run column by column: byte r + 4c is row r of column c
  function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*c) -: 8] = sb_fwd[byte_at(s, r + 4*((c + r) % 4))];
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*((c + r) % 4)) -: 8] = sb_inv[byte_at(s, r + 4*c)];
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s, input bit inverse);
    logic [127:0] t;
    logic [7:0]   a [4];
    logic [7:0]   m [4];
    if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = byte_at(s, 4*c + r);
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1]) ^
                                gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
    end
    return t;
  endfunction

  function automatic logic [127:0] encrypt_block(input logic [127:0] s);
    s = s ^ rkey[0];
    for (int r = 1; r < 10; r++) s = mix_cols(fwd_sub_shift(s), 1'b0) ^ rkey[r];
    return fwd_sub_shift(s) ^ rkey[10];
  endfunction

  function automatic logic [127:0] decrypt_block(input logic [127:0] s);
    s = s ^ rkey[10];
    for (int r = 9; r >= 1; r--) s = mix_cols(inv_sub_shift(s) ^ rkey[r], 1'b1);
    return inv_sub_shift(s) ^ rkey[0];
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[63-8*i -: 8] = v[8*i +: 8];
    return r;
  endfunction

  // work out the output block of one accepted item and advance the chain
  function automatic void predict_block(input block_item_t it);
    logic [127:0] din, res;
    int           keep;
    din = {it.hi, it.lo};
    expand_key();
    if (it.first) begin
      chain_val = {cur_iv_hi, cur_iv_lo};
      blk_count = '0;
    end
    case (cur_mode)
      MODE_ECB_ENC: res = encrypt_block(din);
      MODE_ECB_DEC: res = decrypt_block(din);
      MODE_CBC_ENC: begin
        res = encrypt_block(din ^ chain_val);
        chain_val = res;
      end
      MODE_CBC_DEC: begin
        res = decrypt_block(din) ^ chain_val;
        chain_val = din;
      end
      MODE_CTR: begin
        res = encrypt_block({cur_iv_hi, swap64(blk_count)}) ^ din;
        keep = (it.nbytes > 16) ? 16 : it.nbytes;
        for (int i = keep; i < 16; i++) res[127-8*i -: 8] = 8'h00;
        blk_count = blk_count + 64'd1;
      end
      default: res = '0;
    endcase
    expected_blocks.push_back(res);
  endfunction

  function automatic int pick_gap(input bit burst);
    int roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // sender: hold each item until taken, then pull the next one from the queue
  always @(posedge clk_i or negedge rst_ni) begin
    block_item_t nxt;
    block_item_t taken;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
      in_burst <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        taken.hi = data_hi;
        taken.lo = data_lo;
        taken.nbytes = valid_bytes;
        taken.first = first_block;
        predict_block(taken);
      end
      if ($urandom_range(0, 199) == 0) in_burst <= ~in_burst;
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          nxt = pending_blocks.pop_front();
          data_hi <= nxt.hi;
          data_lo <= nxt.lo;
          valid_bytes <= nxt.nbytes;
          first_block <= nxt.first;
          in_valid <= 1'b1;
          in_gap <= pick_gap(in_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall at random, check each output item against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap <= 0;
      out_burst <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected output item hi=%h lo=%h", $time, out_hi_o, out_lo_o);
          failed = 1'b1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_hi_o !== want[127:64]) begin
            $display("%0t: out_hi expected %h actual %h", $time, want[127:64], out_hi_o);
            failed = 1'b1;
          end
          if (out_lo_o !== want[63:0]) begin
            $display("%0t: out_lo expected %h actual %h", $time, want[63:0], out_lo_o);
            failed = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) out_burst <= ~out_burst;
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_gap <= pick_gap(out_burst);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE:   cur_mode = val[2:0];
      REG_KEY_HI: cur_key_hi = val;
      REG_KEY_LO: cur_key_lo = val;
      REG_IV_HI:  cur_iv_hi = val;
      REG_IV_LO:  cur_iv_lo = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] md, input logic [63:0] khi, input logic [63:0] klo,
                            input logic [63:0] ivh, input logic [63:0] ivl);
    write_reg(REG_KEY_HI, khi);
    write_reg(REG_KEY_LO, klo);
    write_reg(REG_IV_HI, ivh);
    write_reg(REG_IV_LO, ivl);
    write_reg(REG_MODE, {61'd0, md});
  endtask

  // wait until every item has gone through, then let the engine settle
  task automatic drain();
    do @(posedge clk_i);
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void push_block(input logic [63:0] hi, input logic [63:0] lo,
                                     input logic [4:0] nb, input logic fb);
    block_item_t it;
    it.hi = hi;
    it.lo = lo;
    it.nbytes = nb;
    it.first = fb;
    pending_blocks.push_back(it);
  endfunction

  function automatic logic [63:0] pick64();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // messages of random length with random content; some stray restarts
  function automatic void queue_messages(input logic [2:0] md, input int count);
    int         left;
    logic       fb;
    logic [4:0] nb;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        left = $urandom_range(1, 8);
        fb = 1'b1;
      end else begin
        fb = ($urandom_range(0, 19) == 0);
      end
      left--;
      if (md == MODE_CTR) begin
        nb = (left == 0) ? 5'($urandom_range(1, 16)) : 5'd16;
        if ($urandom_range(0, 15) == 0) nb = 5'($urandom_range(0, 31));
      end else begin
        nb = 5'($urandom_range(0, 31));
      end
      push_block(pick64(), pick64(), nb, fb);
    end
  endfunction

  initial begin
    logic [2:0] md;
    cur_mode = MODE_ECB_ENC;
    cur_key_hi = '0;
    cur_key_lo = '0;
    cur_iv_hi = '0;
    cur_iv_lo = '0;
    fill_sboxes();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, extreme blocks, chained modes continuing past the first block
    push_block('0, '0, 5'd16, 1'b0);
    push_block('1, '1, 5'd16, 1'b0);
    drain();
    set_config(MODE_ECB_DEC, '1, '1, '1, '1);
    push_block('0, '0, 5'd16, 1'b1);
    push_block('1, '1, 5'd0, 1'b0);
    drain();
    set_config(MODE_CBC_ENC, pick64(), pick64(), pick64(), pick64());
    push_block(pick64(), pick64(), 5'd16, 1'b1);
    push_block(pick64(), pick64(), 5'd31, 1'b0);
    drain();
    write_reg(REG_MODE, {61'd0, MODE_CBC_DEC});
    push_block(pick64(), pick64(), 5'd16, 1'b1);
    push_block(pick64(), pick64(), 5'd16, 1'b0);
    drain();
    // short and oversized counter-mode blocks
    set_config(MODE_CTR, pick64(), pick64(), '1, pick64());
    push_block('1, '1, 5'd0, 1'b1);
    push_block('1, '1, 5'd1, 1'b0);
    push_block('1, '1, 5'd8, 1'b0);
    push_block('1, '1, 5'd15, 1'b0);
    push_block('1, '1, 5'd16, 1'b0);
    push_block('1, '1, 5'd17, 1'b0);
    push_block('1, '1, 5'd31, 1'b0);
    drain();
    // unused modes and an unused register index
    write_reg(RegUnused, '1);
    write_reg(REG_MODE, {61'd0, ModeSpare5});
    push_block(pick64(), pick64(), 5'd16, 1'b1);
    drain();
    write_reg(REG_MODE, {61'd0, ModeSpare7});
    push_block(pick64(), pick64(), 5'd16, 1'b0);
    drain();

    // random phases through every mode; keys and vectors often at their extremes
    for (int p = 0; p < 14; p++) begin
      md = 3'(p % 5);
      if (p == 13) md = MODE_CTR;
      set_config(md, pick64(), pick64(), pick64(), pick64());
      queue_messages(md, 88);
      drain();
    end

    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
